// ===== rtl/opd_pkg.sv =====
// ----------------------------------------------------------------------------
// opd_pkg
// Shared constants and types for the oscillation peak detector: window
// geometry, sum widths, register indexes and the window control and view.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

    // Window geometry
    localparam int HALF_WINDOW = 6;
    localparam int SAMPLE_BITS = 10;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
    // Half-window sum must hold HALF_WINDOW full-scale samples
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(HALF_WINDOW + 1);

    // Field widths
    localparam int PRES_BITS  = 10;
    localparam int MS_BITS    = 16;
    localparam int PULSE_BITS = 8;
    localparam int CNT_BITS   = 8;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERFLOW_LIMIT  = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_PRESSURE   = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY_MS   = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TIMEOUT_MS = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_PULSE_MS   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_OPEN_MS = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PEAKS       = 4'd7;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] RST_PEAK_THRESHOLD  = 10'd25;
    localparam logic [SAMPLE_BITS-1:0] RST_OVERFLOW_LIMIT  = 10'd600;
    localparam logic [PRES_BITS-1:0]   RST_STOP_PRESSURE   = 10'd100;
    localparam logic [MS_BITS-1:0]     RST_REFRACTORY_MS   = 16'd400;
    localparam logic [MS_BITS-1:0]     RST_IDLE_TIMEOUT_MS = 16'd2000;
    localparam logic [PULSE_BITS-1:0]  RST_IDLE_PULSE_MS   = 8'd30;
    localparam logic [PULSE_BITS-1:0]  RST_INITIAL_OPEN_MS = 8'd7;
    localparam logic [CNT_BITS-1:0]    RST_MAX_PEAKS       = 8'd255;

    // Input op codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Window control: one of shift or fill per sample beat
    typedef struct packed {
        logic shift;
        logic fill;
    } t_win_ctrl;

    // Window contents as they stand after a shift by the incoming sample
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mid;
        logic [SUM_BITS-1:0]    newer_sum;
        logic [SUM_BITS-1:0]    older_sum;
    } t_win_view;

endpackage

`default_nettype wire

// ===== rtl/opd_cell.sv =====
// ----------------------------------------------------------------------------
// opd_cell
// One window slot: takes its neighbor's sample on a shift, or the head
// sample on a fill, and holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_cell
    import opd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_win_ctrl              i_ctrl,
    input  wire logic [SAMPLE_BITS-1:0] i_prev,
    input  wire logic [SAMPLE_BITS-1:0] i_fill_value,
    output logic      [SAMPLE_BITS-1:0] o_data
);

    logic [SAMPLE_BITS-1:0] r_data;
    logic [SAMPLE_BITS-1:0] n_data;

    // Next slot value
    always_comb begin
        n_data = r_data;
        if (i_ctrl.fill) begin
            n_data = i_fill_value;
        end else if (i_ctrl.shift) begin
            n_data = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/opd_window.sv =====
// ----------------------------------------------------------------------------
// opd_window
// Chain of sample cells plus running sums of the newer and older halves.
// Presents the middle sample and both sums as they stand after a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_window
    import opd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_win_ctrl              i_ctrl,
    input  wire logic [SAMPLE_BITS-1:0] i_osc,
    output t_win_view                   o_view
);

    logic [SAMPLE_BITS-1:0] w_tap [WIN_LEN];
    logic [SUM_BITS-1:0]    r_newer_sum;
    logic [SUM_BITS-1:0]    r_older_sum;
    logic [SUM_BITS-1:0]    n_newer_sum;
    logic [SUM_BITS-1:0]    n_older_sum;
    logic [SUM_BITS-1:0]    w_shift_newer;
    logic [SUM_BITS-1:0]    w_shift_older;
    logic [SUM_BITS-1:0]    w_fill_sum;

    // Cell row; slot 0 is the newest sample
    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        if (g == 0) begin : g_head
            opd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_prev       (i_osc),
                .i_fill_value (i_osc),
                .o_data       (w_tap[g])
            );
        end else begin : g_body
            opd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_prev       (w_tap[g-1]),
                .i_fill_value (i_osc),
                .o_data       (w_tap[g])
            );
        end
    end

    // Sums after a shift: newer half gains the new sample and loses the one
    // moving to the middle; older half gains the old middle, loses the tail
    assign w_shift_newer = r_newer_sum + SUM_BITS'(i_osc)
                         - SUM_BITS'(w_tap[HALF_WINDOW-1]);
    assign w_shift_older = r_older_sum + SUM_BITS'(w_tap[HALF_WINDOW])
                         - SUM_BITS'(w_tap[WIN_LEN-1]);
    assign w_fill_sum    = SUM_BITS'(HALF_WINDOW) * SUM_BITS'(i_osc);

    always_comb begin
        n_newer_sum = r_newer_sum;
        n_older_sum = r_older_sum;
        if (i_ctrl.fill) begin
            n_newer_sum = w_fill_sum;
            n_older_sum = w_fill_sum;
        end else if (i_ctrl.shift) begin
            n_newer_sum = w_shift_newer;
            n_older_sum = w_shift_older;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newer_sum <= '0;
            r_older_sum <= '0;
        end else begin
            r_newer_sum <= n_newer_sum;
            r_older_sum <= n_older_sum;
        end
    end

    assign o_view.mid       = w_tap[HALF_WINDOW-1];
    assign o_view.newer_sum = w_shift_newer;
    assign o_view.older_sum = w_shift_older;

endmodule

`default_nettype wire

// ===== rtl/oscillation_peak_detector.sv =====
// ----------------------------------------------------------------------------
// oscillation_peak_detector
// The result beat is registered and appears in the cycle after its input beat
// is accepted. Throughput: one item per cycle; the window and the sums update
// in the accepting cycle. Input stalls only while a held result is stalled.
// Reset: synchronous, active low; clears the window, timers, counters and
// loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module oscillation_peak_detector
    import opd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_op,
    input  wire logic [SAMPLE_BITS-1:0]   i_osc_sample,
    input  wire logic [PRES_BITS-1:0]     i_cuff_pressure,
    input  wire logic                     i_button_held,
    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_peak_valid,
    output logic      [SAMPLE_BITS-1:0]   o_peak_height,
    output logic      [PRES_BITS-1:0]     o_peak_pressure,
    output logic      [CNT_BITS-1:0]      o_peak_index,
    output logic      [PULSE_BITS-1:0]    o_valve_pulse_ms,
    output logic                          o_finished,
    output logic                          o_peak_lost,
    output logic      [CNT_BITS-1:0]      o_peak_total,
    // configuration
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int DIFF_PROD_BITS = PRES_BITS + 8;
    localparam int QUOT_BITS      = 7;
    localparam logic [DIFF_PROD_BITS-1:0] DIV10_MUL = 18'd205;  // 205/2048 ~ 1/10
    localparam int DIV10_SHIFT = 11;
    localparam logic [QUOT_BITS-1:0]  NEXT_CAP    = 7'd50;
    localparam logic [PULSE_BITS-1:0] NEXT_FORCED = 8'd3;
    localparam logic [PRES_BITS-1:0]  RISE_MIN    = 10'd10;

    typedef struct packed {
        logic                   peak_valid;
        logic [SAMPLE_BITS-1:0] peak_height;
        logic [PRES_BITS-1:0]   peak_pressure;
        logic [CNT_BITS-1:0]    peak_index;
        logic [PULSE_BITS-1:0]  valve_pulse_ms;
        logic                   finished;
        logic                   peak_lost;
        logic [CNT_BITS-1:0]    peak_total;
    } t_result;

    // Configuration registers
    logic [SAMPLE_BITS-1:0] r_peak_threshold;
    logic [SAMPLE_BITS-1:0] r_overflow_limit;
    logic [PRES_BITS-1:0]   r_stop_pressure;
    logic [MS_BITS-1:0]     r_refractory_ms;
    logic [MS_BITS-1:0]     r_idle_timeout_ms;
    logic [PULSE_BITS-1:0]  r_idle_pulse_ms;
    logic [PULSE_BITS-1:0]  r_initial_open_ms;
    logic [CNT_BITS-1:0]    r_max_peaks;

    // Detector state
    logic [MS_BITS-1:0]     r_elapsed_ms,   n_elapsed_ms;
    logic [PRES_BITS-1:0]   r_start_pres,   n_start_pres;
    logic [PULSE_BITS-1:0]  r_next_open_ms, n_next_open_ms;
    logic [CNT_BITS-1:0]    r_peak_count,   n_peak_count;
    logic                   r_armed,        n_armed;

    // Result register
    logic                   r_out_valid, n_out_valid;
    t_result                r_result,    n_result;

    logic                   w_in_acc;
    logic                   w_out_acc;
    t_win_ctrl              w_win_ctrl;
    t_win_view              w_view;

    logic                   w_finish;
    logic                   w_idle;
    logic                   w_overflow;
    logic                   w_peak;
    logic                   w_record;
    logic [MS_BITS-1:0]     w_elapsed_eval;
    logic [PRES_BITS-1:0]   w_start_cur;
    logic [PULSE_BITS-1:0]  w_open_cur;
    logic [SUM_BITS-1:0]    w_mid_scaled;
    logic [PRES_BITS-1:0]   w_drop;
    logic [DIFF_PROD_BITS-1:0] w_drop_prod;
    logic [QUOT_BITS-1:0]   w_drop_q;
    logic [PULSE_BITS-1:0]  w_next_len;

    // Handshakes
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_threshold  <= RST_PEAK_THRESHOLD;
            r_overflow_limit  <= RST_OVERFLOW_LIMIT;
            r_stop_pressure   <= RST_STOP_PRESSURE;
            r_refractory_ms   <= RST_REFRACTORY_MS;
            r_idle_timeout_ms <= RST_IDLE_TIMEOUT_MS;
            r_idle_pulse_ms   <= RST_IDLE_PULSE_MS;
            r_initial_open_ms <= RST_INITIAL_OPEN_MS;
            r_max_peaks       <= RST_MAX_PEAKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PEAK_THRESHOLD:  r_peak_threshold  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_OVERFLOW_LIMIT:  r_overflow_limit  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_STOP_PRESSURE:   r_stop_pressure   <= i_cfg_data[PRES_BITS-1:0];
                REG_REFRACTORY_MS:   r_refractory_ms   <= i_cfg_data[MS_BITS-1:0];
                REG_IDLE_TIMEOUT_MS: r_idle_timeout_ms <= i_cfg_data[MS_BITS-1:0];
                REG_IDLE_PULSE_MS:   r_idle_pulse_ms   <= i_cfg_data[PULSE_BITS-1:0];
                REG_INITIAL_OPEN_MS: r_initial_open_ms <= i_cfg_data[PULSE_BITS-1:0];
                REG_MAX_PEAKS:       r_max_peaks       <= i_cfg_data[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sample window
    opd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_win_ctrl),
        .i_osc   (i_osc_sample),
        .o_view  (w_view)
    );

    // Sample decisions
    assign w_finish       = (i_cuff_pressure <= r_stop_pressure) || !i_button_held;
    assign w_idle         = r_armed && (r_elapsed_ms > r_idle_timeout_ms);
    assign w_overflow     = i_osc_sample >= r_overflow_limit;
    assign w_elapsed_eval = (!r_armed || w_idle) ? '0 : r_elapsed_ms;
    assign w_start_cur    = r_armed ? r_start_pres : i_cuff_pressure;
    assign w_open_cur     = r_armed ? r_next_open_ms : r_initial_open_ms;
    assign w_mid_scaled   = SUM_BITS'(HALF_WINDOW) * SUM_BITS'(w_view.mid);

    // Peak test; an arming beat is not yet armed and never peaks
    assign w_peak = r_armed && !w_finish && !w_overflow
                 && (w_elapsed_eval > r_refractory_ms)
                 && (w_view.mid > r_peak_threshold)
                 && (w_view.older_sum < w_mid_scaled)
                 && (w_view.newer_sum < w_mid_scaled);
    assign w_record = w_peak && (r_peak_count < r_max_peaks);

    // Next pulse length: pressure drop / 10, forced to 3 above the cap or
    // on a rise of ten counts or more, and zero on a smaller rise
    assign w_drop      = w_start_cur - i_cuff_pressure;
    assign w_drop_prod = DIFF_PROD_BITS'(w_drop) * DIV10_MUL;
    assign w_drop_q    = w_drop_prod[DIV10_SHIFT +: QUOT_BITS];

    always_comb begin
        if (i_cuff_pressure > w_start_cur) begin
            w_next_len = ((i_cuff_pressure - w_start_cur) >= RISE_MIN) ? NEXT_FORCED : '0;
        end else if (w_drop_q > NEXT_CAP) begin
            w_next_len = NEXT_FORCED;
        end else begin
            w_next_len = PULSE_BITS'(w_drop_q);
        end
    end

    // Window control
    always_comb begin
        w_win_ctrl = '0;
        if (w_in_acc && (i_op == OP_SAMPLE)) begin
            w_win_ctrl.fill  = !r_armed || (!w_finish && w_overflow);
            w_win_ctrl.shift = !w_win_ctrl.fill;
        end
    end

    // State and result update
    always_comb begin
        n_elapsed_ms   = r_elapsed_ms;
        n_start_pres   = r_start_pres;
        n_next_open_ms = r_next_open_ms;
        n_peak_count   = r_peak_count;
        n_armed        = r_armed;
        n_result       = r_result;
        n_out_valid    = r_out_valid;

        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end

        if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_result    = '0;
            if (i_op == OP_TICK) begin
                if (r_elapsed_ms != '1) begin
                    n_elapsed_ms = r_elapsed_ms + 1'b1;
                end
            end else begin
                n_start_pres   = w_start_cur;
                n_next_open_ms = w_open_cur;
                n_elapsed_ms   = w_elapsed_eval;
                n_armed        = !w_finish;
                if (w_idle) begin
                    n_result.valve_pulse_ms = r_idle_pulse_ms;
                end
                n_result.finished = w_finish;
                if (w_peak) begin
                    n_result.valve_pulse_ms = w_open_cur;
                    n_elapsed_ms            = '0;
                    n_next_open_ms          = w_next_len;
                    n_result.peak_lost      = !w_record;
                end
                if (w_record) begin
                    n_result.peak_valid    = 1'b1;
                    n_result.peak_height   = w_view.mid;
                    n_result.peak_pressure = i_cuff_pressure;
                    n_result.peak_index    = r_peak_count;
                    n_peak_count           = r_peak_count + 1'b1;
                end
            end
            n_result.peak_total = n_peak_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed_ms   <= '0;
            r_start_pres   <= '0;
            r_next_open_ms <= '0;
            r_peak_count   <= '0;
            r_armed        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_elapsed_ms   <= n_elapsed_ms;
            r_start_pres   <= n_start_pres;
            r_next_open_ms <= n_next_open_ms;
            r_peak_count   <= n_peak_count;
            r_armed        <= n_armed;
            r_out_valid    <= n_out_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_out_valid      = r_out_valid;
    assign o_peak_valid     = r_result.peak_valid;
    assign o_peak_height    = r_result.peak_height;
    assign o_peak_pressure  = r_result.peak_pressure;
    assign o_peak_index     = r_result.peak_index;
    assign o_valve_pulse_ms = r_result.valve_pulse_ms;
    assign o_finished       = r_result.finished;
    assign o_peak_lost      = r_result.peak_lost;
    assign o_peak_total     = r_result.peak_total;

endmodule

`default_nettype wire
